FILE: hw/rtl/cfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_pkg
// Shared types and constants of the continued fraction expander.
// ----------------------------------------------------------------------------
package cfe_pkg;

  localparam int unsigned WordW = 64;

  localparam logic OP_EXPAND = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic [7:0]  EASY_TERMS_RESET    = 8'd4;
  localparam logic [63:0] EASY_QUOTIENT_RESET = 64'd10;

  localparam logic REG_EASY_TERMS    = 1'b0;
  localparam logic REG_EASY_QUOTIENT = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [63:0] first_value;
    logic [63:0] second_value;
    logic [7:0]  term_index;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  term_count;
    logic [63:0] largest_quotient;
    logic        is_easy;
    logic [63:0] quotient;
    logic [63:0] numerator;
    logic [63:0] denominator;
    logic        index_valid;
  } out_word_t;

endpackage

FILE: hw/rtl/cfe_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cfe_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quotient,
  output logic [63:0] remainder
);

  logic [63:0] quo_r, quo_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] dvs_r, dvs_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [64:0] trial;
  logic [64:0] shifted;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, quo_r[63]};
    trial    = shifted - {1'b0, dvs_r};
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!trial[64]) begin
        rem_nxt = trial[63:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted[63:0];
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

FILE: hw/rtl/continued_fraction_expander_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// continued_fraction_expander_unit
// Euclidean continued fraction expansion with stored terms and convergents.
// ----------------------------------------------------------------------------
// An expand word runs the Euclidean algorithm on the ordered pair on one
// shared bit-serial divider. In the divide state each division is launched,
// forms 64 quotient bits and then has its result picked up. Then comes the
// convergent update on one shared 32x32 multiplier, three partial products
// for the numerator and three for the denominator. A pair with a zero
// operand skips the divider and goes straight to the output state, and a
// query word passes through two read states first. busy is high for the
// whole item, and the single result appears on out_valid for one cycle, the
// first with busy low again; the receiver cannot stall, so it must take
// the word in that cycle.
module continued_fraction_expander_unit #(
  parameter int unsigned MAX_TERMS = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cfe_pkg::in_word_t  in_word,
  output logic               out_valid,
  output cfe_pkg::out_word_t out_word,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam int unsigned IdxW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned CntW = $clog2(MAX_TERMS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MULH = 3'd2;
  localparam logic [2:0] ST_MULK = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;
  localparam logic [2:0] ST_RD2  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]  st_r, st_nxt;
  logic [7:0]  easy_terms_r;
  logic [63:0] easy_quo_r;
  logic [CntW-1:0] count_r, count_nxt;
  logic [63:0] largest_r, largest_nxt;
  logic [63:0] a_r, a_nxt, b_r, b_nxt;
  logic [63:0] h_prev_r, h_prev_nxt, h_cur_r, h_cur_nxt;
  logic [63:0] k_prev_r, k_prev_nxt, k_cur_r, k_cur_nxt;
  logic [63:0] qi_r, qi_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [7:0]  qidx_r, qidx_nxt;
  logic        qvalid_r, qvalid_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [63:0] acc_r, acc_nxt;

  logic [63:0] quo_mem [MAX_TERMS];
  logic [63:0] num_mem [MAX_TERMS];
  logic [63:0] den_mem [MAX_TERMS];
  logic [63:0] quo_rd_r, num_rd_r, den_rd_r;
  logic        mem_we;
  logic [63:0] mem_wq, mem_wh, mem_wk;

  logic        div_start, div_done;
  logic        div_go_r;
  logic [63:0] div_q, div_r;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p, mul_x, mul_full;
  logic        cfg_we;
  logic        accept;
  logic [63:0] lo, hi;

  cfe_divider u_div (
    .clk, .rst_n, .start(div_go_r), .dividend(a_r), .divisor(b_r),
    .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  assign mul_p  = 64'(mul_a) * 64'(mul_b);
  assign accept = start && (st_r == ST_IDLE);
  assign busy   = (st_r != ST_IDLE);
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    lo = in_word.first_value;
    hi = in_word.second_value;
    if (lo > hi) begin
      lo = in_word.second_value;
      hi = in_word.first_value;
    end
  end

  // The low 64 bits of qi times a convergent term are built from three 32x32
  // partial products; the high-by-high product only reaches bits above 63.
  always_comb begin
    mul_x = (st_r == ST_MULK) ? k_cur_r : h_cur_r;
    unique case (ph_r)
      2'd0: begin
        mul_a = qi_r[31:0];
        mul_b = mul_x[31:0];
      end
      2'd1: begin
        mul_a = qi_r[31:0];
        mul_b = mul_x[63:32];
      end
      default: begin
        mul_a = qi_r[63:32];
        mul_b = mul_x[31:0];
      end
    endcase
    if (ph_r == 2'd0) mul_full = mul_p;
    else              mul_full = {acc_r[63:32] + mul_p[31:0], acc_r[31:0]};
  end

  always_comb begin
    st_nxt = st_r; count_nxt = count_r; largest_nxt = largest_r;
    a_nxt = a_r; b_nxt = b_r; h_prev_nxt = h_prev_r; h_cur_nxt = h_cur_r;
    k_prev_nxt = k_prev_r; k_cur_nxt = k_cur_r; qi_nxt = qi_r; rem_nxt = rem_r;
    qidx_nxt = qidx_r; qvalid_nxt = qvalid_r; ovalid_nxt = 1'b0;
    ph_nxt = ph_r; acc_nxt = acc_r;
    div_start = 1'b0; mem_we = 1'b0;
    mem_wq = qi_r; mem_wh = h_cur_r; mem_wk = k_cur_r;
    unique case (st_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_word.opcode == cfe_pkg::OP_EXPAND) begin
            count_nxt = '0; largest_nxt = '0;
            a_nxt = hi; b_nxt = lo; qvalid_nxt = 1'b0;
            h_prev_nxt = 64'd1; h_cur_nxt = '0; k_prev_nxt = '0; k_cur_nxt = 64'd1;
            if (lo == 64'd0) begin
              st_nxt = ST_OUT;
            end else begin
              st_nxt = ST_DIV;
            end
          end else begin
            qidx_nxt = in_word.term_index;
            st_nxt = ST_RD;
          end
        end
      end
      ST_DIV: begin
        // The divider is restarted on entry; the state waits for its done.
        if (div_done) begin
          qi_nxt = div_q; rem_nxt = div_r;
          st_nxt = ST_MULH;
        end
      end
      ST_MULH: begin
        acc_nxt = mul_full;
        if (ph_r != 2'd2) begin
          ph_nxt = ph_r + 2'd1;
        end else begin
          ph_nxt = 2'd0;
          if (count_r == '0) begin
            h_cur_nxt = qi_r;
          end else begin
            h_prev_nxt = h_cur_r; h_cur_nxt = mul_full + h_prev_r;
          end
          st_nxt = ST_MULK;
        end
      end
      ST_MULK: begin
        acc_nxt = mul_full;
        if (ph_r != 2'd2) begin
          ph_nxt = ph_r + 2'd1;
        end else begin
          ph_nxt = 2'd0;
          if (count_r == '0) begin
            mem_wk = 64'd1;
          end else begin
            mem_wk = mul_full + k_prev_r;
            k_prev_nxt = k_cur_r; k_cur_nxt = mem_wk;
          end
          mem_we = 1'b1;
          if (qi_r > largest_r) largest_nxt = qi_r;
          count_nxt = count_r + 1'b1;
          a_nxt = b_r; b_nxt = rem_r;
          if (rem_r == 64'd0 || count_nxt == CntW'(MAX_TERMS)) begin
            st_nxt = ST_OUT;
          end else begin
            st_nxt = ST_DIV;
          end
        end
      end
      ST_RD: begin
        qvalid_nxt = (32'(qidx_r) < 32'(count_r)) && (32'(qidx_r) < MAX_TERMS);
        st_nxt = ST_RD2;
      end
      ST_RD2: begin
        st_nxt = ST_OUT;
      end
      ST_OUT: begin
        ovalid_nxt = 1'b1;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
    if ((st_r == ST_IDLE && accept && in_word.opcode == cfe_pkg::OP_EXPAND && lo != 64'd0)
        || (st_r == ST_MULK && st_nxt == ST_DIV)) begin
      div_start = 1'b1;
    end
  end

  // Divider operands come from a_r/b_r, so its start is registered and reaches it once they are loaded.
  always_ff @(posedge clk) begin
    if (!rst_n) div_go_r <= 1'b0;
    else        div_go_r <= div_start;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      quo_mem[count_r[IdxW-1:0]] <= mem_wq;
      num_mem[count_r[IdxW-1:0]] <= mem_wh;
      den_mem[count_r[IdxW-1:0]] <= mem_wk;
    end
    quo_rd_r <= quo_mem[qidx_r[IdxW-1:0]];
    num_rd_r <= num_mem[qidx_r[IdxW-1:0]];
    den_rd_r <= den_mem[qidx_r[IdxW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; count_r <= '0; largest_r <= '0; qvalid_r <= 1'b0;
      ovalid_r <= 1'b0; ph_r <= 2'd0;
      easy_terms_r <= cfe_pkg::EASY_TERMS_RESET;
      easy_quo_r   <= cfe_pkg::EASY_QUOTIENT_RESET;
    end else begin
      st_r <= st_nxt; count_r <= count_nxt; largest_r <= largest_nxt;
      qvalid_r <= qvalid_nxt; ovalid_r <= ovalid_nxt; ph_r <= ph_nxt;
      if (cfg_we && paddr[2:0] == 3'd0) begin
        if (paddr[3] == cfe_pkg::REG_EASY_TERMS)    easy_terms_r <= pwdata[7:0];
        if (paddr[3] == cfe_pkg::REG_EASY_QUOTIENT) easy_quo_r   <= pwdata;
      end
    end
    a_r <= a_nxt; b_r <= b_nxt; h_prev_r <= h_prev_nxt; h_cur_r <= h_cur_nxt;
    k_prev_r <= k_prev_nxt; k_cur_r <= k_cur_nxt; qi_r <= qi_nxt; rem_r <= rem_nxt;
    qidx_r <= qidx_nxt; acc_r <= acc_nxt;
  end

  always_comb begin
    if (paddr[3] == cfe_pkg::REG_EASY_TERMS) prdata = {56'd0, easy_terms_r};
    else                                     prdata = easy_quo_r;
  end

  logic [7:0] cnt8;
  assign cnt8 = 8'(count_r);

  always_comb begin
    out_valid                 = ovalid_r;
    out_word.term_count       = cnt8;
    out_word.largest_quotient = largest_r;
    out_word.is_easy          = (32'(count_r) <= 32'(easy_terms_r))
                                && (largest_r <= easy_quo_r);
    out_word.index_valid      = qvalid_r;
    out_word.quotient         = qvalid_r ? quo_rd_r : 64'd0;
    out_word.numerator        = qvalid_r ? num_rd_r : 64'd0;
    out_word.denominator      = qvalid_r ? den_rd_r : 64'd1;
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the continued fraction expander against typed answers and a behavioral predictor:
// directed corner words, then random expand and query words under several
// easy-limit settings, with bursty input and field-by-field result checks.
// ----------------------------------------------------------------------------
module tb;

  localparam int TermCap   = 128;
  localparam int IdleLimit = 40000;
  localparam int DirN      = 16;
  localparam logic [3:0] AddrTerms    = 4'(8 * cfe_pkg::REG_EASY_TERMS);
  localparam logic [3:0] AddrQuotient = 4'(8 * cfe_pkg::REG_EASY_QUOTIENT);
  localparam logic [63:0] Ones = '1;
  localparam logic [63:0] FibHi = 64'd12200160415121876738;
  localparam logic [63:0] FibLo = 64'd7540113804746346429;

  logic clk, rst_n, start, busy, out_valid, psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [63:0] pwdata, prdata;
  cfe_pkg::in_word_t in_word;
  cfe_pkg::out_word_t out_word;

  continued_fraction_expander_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  // Shadow state of the expander.
  logic [63:0] quo_mem [TermCap];
  logic [63:0] num_mem [TermCap];
  logic [63:0] den_mem [TermCap];
  int unsigned term_total;
  logic [63:0] top_quotient;
  logic [7:0]  lim_terms;
  logic [63:0] lim_quotient;

  cfe_pkg::out_word_t pending_results[$];
  int errors, accepted, results_seen, expands, queries, idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic cfe_pkg::out_word_t expand_or_lookup(cfe_pkg::in_word_t w);
    cfe_pkg::out_word_t r;
    logic [63:0] a, b, p, q, qi, rem, h0, h1, k0, k1, hn, kn;
    r = '0;
    r.denominator = 64'd1;
    if (w.opcode == cfe_pkg::OP_EXPAND) begin
      term_total = 0;
      top_quotient = '0;
      if (w.first_value != 0 && w.second_value != 0) begin
        p = (w.first_value > w.second_value) ? w.second_value : w.first_value;
        q = (w.first_value > w.second_value) ? w.first_value : w.second_value;
        a = q;
        b = p;
        h0 = 64'd1; h1 = '0; k0 = '0; k1 = 64'd1;
        while (b != 0 && term_total < TermCap) begin
          qi = a / b;
          rem = a % b;
          if (term_total == 0) begin
            h1 = qi;
            k1 = 64'd1;
          end else begin
            hn = qi * h1 + h0;
            kn = qi * k1 + k0;
            h0 = h1; h1 = hn;
            k0 = k1; k1 = kn;
          end
          quo_mem[term_total] = qi;
          num_mem[term_total] = h1;
          den_mem[term_total] = k1;
          if (qi > top_quotient) top_quotient = qi;
          term_total++;
          a = b;
          b = rem;
        end
      end
    end else if (w.term_index < term_total) begin
      r.quotient = quo_mem[w.term_index];
      r.numerator = num_mem[w.term_index];
      r.denominator = den_mem[w.term_index];
      r.index_valid = 1'b1;
    end
    r.term_count = 8'(term_total);
    r.largest_quotient = top_quotient;
    r.is_easy = (term_total <= lim_terms) && (top_quotient <= lim_quotient);
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch on result %0d, %s: got %h, expected %h", results_seen, what, got, want);
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report("unexpected word", 64'd0, 64'd0);
      end else begin
        cfe_pkg::out_word_t e;
        e = pending_results.pop_front();
        if (out_word.term_count != e.term_count)
          report("term_count", 64'(out_word.term_count), 64'(e.term_count));
        if (out_word.largest_quotient != e.largest_quotient)
          report("largest_quotient", out_word.largest_quotient, e.largest_quotient);
        if (out_word.is_easy != e.is_easy)
          report("is_easy", 64'(out_word.is_easy), 64'(e.is_easy));
        if (out_word.quotient != e.quotient)
          report("quotient", out_word.quotient, e.quotient);
        if (out_word.numerator != e.numerator)
          report("numerator", out_word.numerator, e.numerator);
        if (out_word.denominator != e.denominator)
          report("denominator", out_word.denominator, e.denominator);
        if (out_word.index_valid != e.index_valid)
          report("index_valid", 64'(out_word.index_valid), 64'(e.index_valid));
      end
      results_seen++;
    end
  end

  // Watchdog on cycles in which no word moves in either direction.
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Leaves start high; the caller lowers it at the end of a burst.
  // busy is settled at the falling edge, so the word is taken at the next
  // rising edge once busy is seen low there.
  task automatic send_word(cfe_pkg::in_word_t w, bit known, cfe_pkg::out_word_t want);
    cfe_pkg::out_word_t p;
    in_word <= w;
    start <= 1'b1;
    while (busy) @(negedge clk);
    @(posedge clk);
    p = expand_or_lookup(w);
    pending_results.push_back(known ? want : p);
    accepted++;
    if (w.opcode == cfe_pkg::OP_EXPAND) expands++;
    else queries++;
    @(negedge clk);
  endtask

  task automatic drain();
    while (pending_results.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_reg(logic [3:0] addr, logic [63:0] value);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == AddrTerms) lim_terms = value[7:0];
    else lim_quotient = value;
  endtask

  task automatic set_limits(logic [7:0] t, logic [63:0] q);
    start <= 1'b0;
    @(negedge clk);
    drain();
    write_reg(AddrTerms, 64'(t));
    write_reg(AddrQuotient, q);
  endtask

  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    int w;
    v = {$urandom, $urandom};
    w = $urandom_range(1, 64);
    if ($urandom_range(0, 3) == 0) w = 64;
    return (w == 64) ? v : (v & ((64'd1 << w) - 1));
  endfunction

  function automatic cfe_pkg::in_word_t mk(logic op, logic [63:0] f, logic [63:0] s,
                                           logic [7:0] i);
    cfe_pkg::in_word_t w;
    w.opcode = op; w.first_value = f; w.second_value = s; w.term_index = i;
    return w;
  endfunction

  function automatic cfe_pkg::out_word_t res(logic [7:0] c, logic [63:0] lq, logic e,
                                             logic [63:0] q, logic [63:0] n,
                                             logic [63:0] d, logic v);
    cfe_pkg::out_word_t r;
    r.term_count = c; r.largest_quotient = lq; r.is_easy = e; r.quotient = q;
    r.numerator = n; r.denominator = d; r.index_valid = v;
    return r;
  endfunction

  cfe_pkg::in_word_t  dir_word  [DirN];
  bit                 dir_known [DirN];
  cfe_pkg::out_word_t dir_want  [DirN];

  initial begin
    int burst, phase, n;
    cfe_pkg::in_word_t w;
    start = 1'b0; in_word = '0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0; rst_n = 1'b0;
    errors = 0; accepted = 0; results_seen = 0; expands = 0; queries = 0;
    idle_cycles = 0; term_total = 0; top_quotient = '0;
    lim_terms = cfe_pkg::EASY_TERMS_RESET; lim_quotient = cfe_pkg::EASY_QUOTIENT_RESET;

    // Directed words; rows without a typed answer go to the predictor.
    dir_word[0]  = mk(cfe_pkg::OP_QUERY, '0, '0, 8'd0);
    dir_want[0]  = res(8'd0, '0, 1'b1, '0, '0, 64'd1, 1'b0);
    dir_word[1]  = mk(cfe_pkg::OP_EXPAND, '0, 64'd5, 8'd0);
    dir_want[1]  = res(8'd0, '0, 1'b1, '0, '0, 64'd1, 1'b0);
    dir_word[2]  = mk(cfe_pkg::OP_EXPAND, 64'd5, '0, 8'hFF);
    dir_want[2]  = res(8'd0, '0, 1'b1, '0, '0, 64'd1, 1'b0);
    dir_word[3]  = mk(cfe_pkg::OP_EXPAND, Ones, Ones, 8'd0);
    dir_want[3]  = res(8'd1, 64'd1, 1'b1, '0, '0, 64'd1, 1'b0);
    dir_word[4]  = mk(cfe_pkg::OP_QUERY, Ones, Ones, 8'd0);
    dir_want[4]  = res(8'd1, 64'd1, 1'b1, 64'd1, 64'd1, 64'd1, 1'b1);
    dir_word[5]  = mk(cfe_pkg::OP_EXPAND, Ones, 64'd1, 8'd0);
    dir_want[5]  = res(8'd1, Ones, 1'b0, '0, '0, 64'd1, 1'b0);
    dir_word[6]  = mk(cfe_pkg::OP_QUERY, '0, '0, 8'd0);
    dir_want[6]  = res(8'd1, Ones, 1'b0, Ones, Ones, 64'd1, 1'b1);
    dir_word[7]  = mk(cfe_pkg::OP_QUERY, '0, '0, 8'hFF);
    dir_want[7]  = res(8'd1, Ones, 1'b0, '0, '0, 64'd1, 1'b0);
    dir_word[8]  = mk(cfe_pkg::OP_EXPAND, FibLo, FibHi, 8'd0);
    dir_word[9]  = mk(cfe_pkg::OP_QUERY, '0, '0, 8'd91);
    dir_word[10] = mk(cfe_pkg::OP_QUERY, '0, '0, 8'd90);
    dir_word[11] = mk(cfe_pkg::OP_QUERY, '0, '0, 8'd92);
    dir_word[12] = mk(cfe_pkg::OP_EXPAND, 64'd355, 64'd113, 8'd0);
    dir_word[13] = mk(cfe_pkg::OP_QUERY, '0, '0, 8'd2);
    dir_word[14] = mk(cfe_pkg::OP_EXPAND, 64'd1000003, 64'd999983, 8'd0);
    dir_word[15] = mk(cfe_pkg::OP_QUERY, Ones, Ones, 8'd3);
    for (int i = 0; i < DirN; i++) dir_known[i] = (i < 8);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < DirN; i++) send_word(dir_word[i], dir_known[i], dir_want[i]);

    // Random part in four limit settings; each change waits for a drained block.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_limits(8'd0, '0);
        1: set_limits(8'd128, Ones);
        2: set_limits(8'($urandom_range(0, 128)), rand_value());
        default: set_limits(8'($urandom_range(1, 12)), 64'($urandom_range(1, 20)));
      endcase
      n = 0;
      while (n < 25) begin
        burst = $urandom_range(1, 6);
        for (int b = 0; b < burst && n < 25; b++) begin
          if ($urandom_range(0, 9) < 4) begin
            w = mk(cfe_pkg::OP_EXPAND, rand_value(), rand_value(), 8'($urandom));
          end else if ($urandom_range(0, 4) == 0 || term_total == 0) begin
            w = mk(cfe_pkg::OP_QUERY, {$urandom, $urandom}, {$urandom, $urandom},
                   8'($urandom));
          end else begin
            w = mk(cfe_pkg::OP_QUERY, {$urandom, $urandom}, {$urandom, $urandom},
                   8'($urandom_range(0, term_total)));
          end
          send_word(w, 1'b0, '0);
          n++;
        end
        if ($urandom_range(0, 2) != 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 20)) @(negedge clk);
        end
      end
    end

    start <= 1'b0;
    @(negedge clk);
    drain();
    repeat (100) @(negedge clk);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0d expected words never arrived", pending_results.size());
    end
    $display("Covered %0d words (%0d expands, %0d queries), %0d results checked,",
             accepted, expands, queries, results_seen);
    $display("under five easy-limit settings including both extremes.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
